// File: design/sha256_hash_engine_top_assert.svh
// Assertion macros for the hash engine.
`ifndef SHA256_HASH_ENGINE_TOP_ASSERT_SVH
`define SHA256_HASH_ENGINE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("sha check");
`define SHA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("sha check");
`else
`define SHA_ASSERT_IMPL(lbl, a, c)
`define SHA_ASSERT_NEXT(lbl, a, c)
`endif
`endif

// File: design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Constants, types and round functions shared by the engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        fin;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_PAD, ST_ROUND, ST_ADD, ST_EMIT
  } state_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_const = k[i];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

// File: design/sha256_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts requests, saturates the byte count and queues them for the core.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_front
  import sha256_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        end_of_message,
  output logic             q_valid,
  input  wire logic        q_ready,
  output req_t             q_req
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  req_t            mem [Depth];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [AW:0]     count;
  logic            push;
  logic            pop;
  req_t            req_in;

  always_comb begin
    req_in.data = data_word;
    req_in.cnt  = (byte_count > 3'd4) ? 3'd4 : byte_count;
    req_in.fin  = end_of_message;
  end

  assign in_ready = (count != (AW+1)'(Depth));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_req    = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// File: design/sha256_core.sv
// ----------------------------------------------------------------------------
// SHA-256 core
// Packs bytes into the block buffer, pads, runs 64 rounds per block and
// emits the digest.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_core
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire req_t        q_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word,
  output logic             busy
);
  state_t      state, state_next;
  logic [31:0] hw [8];
  logic [31:0] wv [8];
  logic [31:0] w  [16];
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [5:0]  rnd;
  logic [2:0]  bcnt;
  logic [31:0] bdata;
  logic        bfin;
  logic        padded;
  logic        lenpend;
  logic        wrap;
  logic [2:0]  oidx;

  logic [7:0]  pbyte;
  logic        push_en;
  logic [31:0] wi;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] x15;
  logic [31:0] x2;
  logic [31:0] s0;
  logic [31:0] s1;

  assign q_ready = (state == ST_IDLE);
  assign busy = (state != ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign digest_word = hw[oidx];
  assign word_index = oidx;
  assign last_word = (oidx == 3'd7);

  always_comb begin
    x15 = w[1];
    x2  = w[14];
    wi  = (rnd < 6'd16) ? w[0] :
          ((ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10)) + w[9] +
           (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + w[0]);
    s1 = ror(wv[4], 6) ^ ror(wv[4], 11) ^ ror(wv[4], 25);
    s0 = ror(wv[0], 2) ^ ror(wv[0], 13) ^ ror(wv[0], 22);
    t1 = wv[7] + s1 + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + round_const(rnd) + wi;
    t2 = s0 + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  always_comb begin
    pbyte = 8'h00;
    push_en = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (bcnt != 3'd0) begin
          pbyte = bdata[31:24];
          push_en = 1'b1;
          if (fill == 6'd63) begin
            state_next = ST_ROUND;
          end
        end else if (bfin) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (!padded) begin
          pbyte = 8'h80;
        end else if (!wrap && fill >= 6'd56) begin
          pbyte = bits[63:56];
        end
        if (fill == 6'd63) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (bcnt != 3'd0) begin
          state_next = ST_LOAD;
        end else if (bfin && lenpend) begin
          state_next = ST_PAD;
        end else if (bfin) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_ready && oidx == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      case (fill[1:0])
        2'd0: w[fill[5:2]][31:24] <= pbyte;
        2'd1: w[fill[5:2]][23:16] <= pbyte;
        2'd2: w[fill[5:2]][15:8]  <= pbyte;
        default: w[fill[5:2]][7:0] <= pbyte;
      endcase
    end else if (state == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= wi;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end else begin
      for (int i = 0; i < 8; i++) begin
        wv[i] <= hw[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        hw[i] <= init_hash(3'(i));
      end
      fill <= '0;
      bits <= '0;
      rnd <= '0;
      oidx <= '0;
      bcnt <= '0;
      bdata <= '0;
      bfin <= 1'b0;
      padded <= 1'b0;
      lenpend <= 1'b0;
      wrap <= 1'b0;
    end else begin
      if (state == ST_IDLE && q_valid) begin
        bdata <= q_req.data;
        bcnt <= q_req.cnt;
        bfin <= q_req.fin;
        bits <= bits + {58'd0, q_req.cnt, 3'd0};
        padded <= 1'b0;
        lenpend <= q_req.fin;
        wrap <= 1'b0;
      end
      if (push_en) begin
        fill <= fill + 6'd1;
        if (state == ST_LOAD) begin
          bdata <= {bdata[23:0], 8'h00};
          bcnt <= bcnt - 3'd1;
        end else if (!padded) begin
          padded <= 1'b1;
          wrap <= (fill >= 6'd56) && (fill != 6'd63);
        end else if (!wrap && fill >= 6'd56) begin
          bits <= {bits[55:0], bits[63:56]};
          if (fill == 6'd63) begin
            lenpend <= 1'b0;
          end
        end else if (fill == 6'd63) begin
          wrap <= 1'b0;
        end
      end
      if (state == ST_ROUND) begin
        rnd <= rnd + 6'd1;
      end
      if (state == ST_ADD) begin
        for (int i = 0; i < 8; i++) begin
          hw[i] <= hw[i] + wv[i];
        end
      end
      if (state == ST_EMIT && out_ready) begin
        oidx <= oidx + 3'd1;
        if (oidx == 3'd7) begin
          for (int i = 0; i < 8; i++) begin
            hw[i] <= init_hash(3'(i));
          end
          bits <= '0;
          fill <= '0;
          padded <= 1'b0;
          bfin <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: design/sha256_hash_engine_top.sv
// ----------------------------------------------------------------------------
// Streaming SHA-256 engine.
// Input channel: in_valid/in_ready with data_word, byte_count (0..4, values
// above four count as four) and end_of_message. Output channel:
// out_valid/out_ready with digest_word, word_index and last_word.
// A four-entry request queue decouples the input from the hashing core, so
// up to four requests are taken while the core is busy.
// The core packs the message one byte at a time and compresses each full
// 64-byte block in 64 rounds followed by an add step; the single shared
// round unit serves every round, and the core takes requests only when idle.
// A final request is padded byte by byte and compressed, then the eight
// digest words are presented one per cycle while out_ready is high.
// When the receiver stalls, the current digest word holds and the core
// waits, and the queue fills and drops in_ready.
// Reset restores the initial hash values and clears the length and queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_hash_engine_top_assert.svh"
module sha256_hash_engine_top
  import sha256_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);
  logic q_valid;
  logic q_ready;
  req_t q_req;
  logic busy;

  sha256_front #(.Depth(Depth)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .data_word(data_word), .byte_count(byte_count), .end_of_message(end_of_message),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  sha256_core u_core (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word), .busy(busy)
  );

  `SHA_ASSERT_IMPL(a_out_busy, out_valid, busy)
  `SHA_ASSERT_IMPL(a_take_idle, q_valid && q_ready, !busy)
  `SHA_ASSERT_NEXT(a_last_done, out_valid && out_ready && last_word, !out_valid)
endmodule
`default_nettype wire
